>>> design/hall_sensor_position_velocity_macros.svh
// Assertion macros for the Hall sensor position and velocity block
`ifndef HALL_SENSOR_POSITION_VELOCITY_MACROS_SVH
`define HALL_SENSOR_POSITION_VELOCITY_MACROS_SVH

// same-cycle implication, disabled while in reset
`define HSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while in reset
`define HSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/hsp_pkg.sv
// Types, constants and the sector table shared by the Hall decoder modules
package hsp_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned TURN_BITS_DEF = 32;

  localparam logic [31:0] RPS_RESET  = 32'd1124419809;
  localparam logic [14:0] VLIM_RESET = 15'd1000;
  localparam logic [19:0] MICRO_SCALE = 20'd1000000;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_RPS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VLIM = 2'd1;

  localparam logic signed [1:0] DIR_NONE = 2'sb00;
  localparam logic signed [1:0] DIR_CW   = 2'sb01;
  localparam logic signed [1:0] DIR_CCW  = 2'sb11;

  // dividend rps * 1e6 fits 52 bits; quotient lands in the same register
  localparam int unsigned DVD_W       = 52;
  localparam int unsigned FRAC_SHIFT  = 14;
  localparam int unsigned ACC_W       = 62;
  localparam int unsigned ANGLE_W     = 48;
  localparam int unsigned MUL_ITERS   = 16;
  localparam int unsigned DIV_ITERS   = DVD_W / 2;
  localparam int unsigned CNT_W       = $clog2(DIV_ITERS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_PREP,
    S_LOAD,
    S_CALC,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic update;
    logic prep;
    logic load;
    logic mul_en;
    logic div_en;
    logic load_out;
  } ctrl_cmd_t;

  function automatic logic signed [3:0] sector_of(input logic [2:0] code);
    logic signed [3:0] s;
    unique case (code)
      3'd1:    s = 4'sd0;
      3'd2:    s = 4'sd4;
      3'd3:    s = 4'sd5;
      3'd4:    s = 4'sd2;
      3'd5:    s = 4'sd1;
      3'd6:    s = 4'sd3;
      default: s = -4'sd1;
    endcase
    return s;
  endfunction

endpackage

>>> design/hsp_ctrl.sv
// Controller state machine sequencing update, multiply, divide and output
module hsp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output hsp_pkg::ctrl_cmd_t cmd
);
  import hsp_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_CALC;
      end
      S_CALC: begin
        cmd.div_en = 1'b1;
        cmd.mul_en = (cnt_r < CNT_W'(MUL_ITERS));
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_ITERS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

>>> design/hsp_datapath.sv
// Datapath: decoder state, config registers, serial multiplier and divider
module hsp_datapath #(
  parameter int unsigned TIME_BITS = hsp_pkg::TIME_BITS_DEF,
  parameter int unsigned TURN_BITS = hsp_pkg::TURN_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hsp_pkg::ctrl_cmd_t              cmd,
  input  logic                            cfg_we,
  input  logic [hsp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  logic                            in_action,
  input  logic                            in_hall_a,
  input  logic                            in_hall_b,
  input  logic                            in_hall_c,
  input  logic [31:0]                     in_now_us,
  output logic signed [3:0]               out_sector,
  output logic signed [1:0]               out_turn_direction,
  output logic signed [31:0]              out_electric_turns,
  output logic signed [31:0]              out_step_count,
  output logic signed [31:0]              out_period_us,
  output logic signed [31:0]              out_velocity,
  output logic signed [hsp_pkg::ANGLE_W-1:0] out_angle,
  output logic                            out_state_changed
);
  import hsp_pkg::*;

  localparam int unsigned STEP_W = TURN_BITS + 4;
  localparam int unsigned VQ_W   = DVD_W - FRAC_SHIFT;

  // configuration
  logic [31:0] rps_r;
  logic [14:0] vlim_r;

  // latched input word
  logic                 action_r;
  logic [2:0]           code_r;
  logic [TIME_BITS-1:0] now_r;

  // decoder state
  logic [2:0]           hall_r, hall_nxt;
  logic signed [3:0]    sector_r, sector_nxt;
  logic signed [1:0]    dir_r, dir_nxt;
  logic signed [1:0]    prev_dir_r, prev_dir_nxt;
  logic [TURN_BITS-1:0] turn_r, turn_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic [TIME_BITS-1:0] period_r, period_nxt;
  logic                 changed_r, changed_nxt;

  // arithmetic
  logic signed [STEP_W-1:0] step_r;
  logic                     vzero_r;
  logic                     negv_r;
  logic [TIME_BITS-1:0]     mag_r;
  logic [ACC_W-1:0]         acc_r, m1_r, m3_r;
  logic [31:0]              mplier_r;
  logic [DVD_W-1:0]         dvd_r;
  logic [TIME_BITS-1:0]     rem_r;

  // output word
  logic signed [3:0]         sector_o_r;
  logic signed [1:0]         dir_o_r;
  logic signed [31:0]        turns_o_r, step_o_r, period_o_r, vel_o_r;
  logic signed [ANGLE_W-1:0] angle_o_r;
  logic                      changed_o_r;

  // update comb
  logic signed [3:0]    new_sector;
  logic signed [4:0]    diff;
  logic signed [1:0]    new_dir;
  logic [TURN_BITS-1:0] new_turn;

  // prep comb
  logic signed [STEP_W-1:0]    turn_ext;
  logic signed [TIME_BITS-1:0] per_s, el_s;

  // calc comb
  logic [ACC_W-1:0]   pp;
  logic [TIME_BITS:0] t1, t2;
  logic               ge1, ge2;
  logic [TIME_BITS-1:0] r1, r2;

  // output comb
  logic [VQ_W-1:0] vq;
  logic            over;
  logic [31:0]     v32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rps_r  <= RPS_RESET;
      vlim_r <= VLIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RPS:  rps_r  <= cfg_wdata;
        REG_VLIM: vlim_r <= cfg_wdata[14:0];
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      action_r <= in_action;
      code_r   <= {in_hall_a, in_hall_b, in_hall_c};
      now_r    <= TIME_BITS'(in_now_us);
    end
  end

  always_comb begin
    new_sector   = sector_of(code_r);
    diff         = 5'(new_sector) - 5'(sector_r);
    new_turn     = turn_r;
    if (diff > 5'sd3) begin
      new_dir  = DIR_CCW;
      new_turn = turn_r - 1'b1;
    end else if (diff < -5'sd3) begin
      new_dir  = DIR_CW;
      new_turn = turn_r + 1'b1;
    end else begin
      new_dir = (new_sector > sector_r) ? DIR_CW : DIR_CCW;
    end

    hall_nxt     = hall_r;
    sector_nxt   = sector_r;
    dir_nxt      = dir_r;
    prev_dir_nxt = prev_dir_r;
    turn_nxt     = turn_r;
    last_nxt     = last_r;
    period_nxt   = period_r;
    changed_nxt  = changed_r;
    if (cmd.update) begin
      changed_nxt = 1'b0;
      if (!action_r && (code_r != hall_r)) begin
        changed_nxt  = 1'b1;
        hall_nxt     = code_r;
        sector_nxt   = new_sector;
        dir_nxt      = new_dir;
        prev_dir_nxt = new_dir;
        turn_nxt     = new_turn;
        last_nxt     = now_r;
        period_nxt   = (new_dir == prev_dir_r) ? (now_r - last_r) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hall_r     <= '0;
      sector_r   <= '0;
      dir_r      <= DIR_NONE;
      prev_dir_r <= DIR_NONE;
      turn_r     <= '0;
      last_r     <= '0;
      period_r   <= '0;
      changed_r  <= 1'b0;
    end else begin
      hall_r     <= hall_nxt;
      sector_r   <= sector_nxt;
      dir_r      <= dir_nxt;
      prev_dir_r <= prev_dir_nxt;
      turn_r     <= turn_nxt;
      last_r     <= last_nxt;
      period_r   <= period_nxt;
      changed_r  <= changed_nxt;
    end
  end

  assign turn_ext = STEP_W'(signed'(turn_r));
  assign per_s    = signed'(period_r);
  assign el_s     = signed'(now_r - last_r);

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      step_r  <= (turn_ext <<< 2) + (turn_ext <<< 1) + STEP_W'(sector_r);
      vzero_r <= (per_s == '0) || (dir_r == DIR_NONE) || (el_s > per_s);
      negv_r  <= (per_s < 0) ^ (dir_r < 0);
      mag_r   <= (per_s < 0) ? (TIME_BITS'(0) - period_r) : period_r;
    end
  end

  // radix-4 multiply digit and two restoring divide steps per cycle
  always_comb begin
    case (mplier_r[1:0])
      2'd0:    pp = '0;
      2'd1:    pp = m1_r;
      2'd2:    pp = m1_r << 1;
      default: pp = m3_r;
    endcase
    t1  = {rem_r, dvd_r[DVD_W-1]};
    ge1 = (t1 >= {1'b0, mag_r});
    r1  = ge1 ? TIME_BITS'(t1 - {1'b0, mag_r}) : t1[TIME_BITS-1:0];
    t2  = {r1, dvd_r[DVD_W-2]};
    ge2 = (t2 >= {1'b0, mag_r});
    r2  = ge2 ? TIME_BITS'(t2 - {1'b0, mag_r}) : t2[TIME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r    <= '0;
      m1_r     <= ACC_W'(step_r);
      m3_r     <= ACC_W'(step_r) + (ACC_W'(step_r) << 1);
      mplier_r <= rps_r;
      dvd_r    <= rps_r * MICRO_SCALE;
      rem_r    <= '0;
    end else begin
      if (cmd.mul_en) begin
        acc_r    <= acc_r + pp;
        m1_r     <= m1_r << 2;
        m3_r     <= m3_r << 2;
        mplier_r <= mplier_r >> 2;
      end
      if (cmd.div_en) begin
        rem_r <= r2;
        dvd_r <= {dvd_r[DVD_W-3:0], ge1, ge2};
      end
    end
  end

  assign vq   = dvd_r[DVD_W-1:FRAC_SHIFT];
  assign over = (vq > VQ_W'({vlim_r, 16'b0}));
  assign v32  = vq[31:0];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      sector_o_r  <= sector_r;
      dir_o_r     <= dir_r;
      turns_o_r   <= 32'(signed'(turn_r));
      step_o_r    <= 32'(step_r);
      period_o_r  <= 32'(per_s);
      vel_o_r     <= (vzero_r || over) ? 32'sd0 : (negv_r ? signed'(-v32) : signed'(v32));
      angle_o_r   <= signed'(acc_r[FRAC_SHIFT +: ANGLE_W]);
      changed_o_r <= changed_r;
    end
  end

  assign out_sector         = sector_o_r;
  assign out_turn_direction = dir_o_r;
  assign out_electric_turns = turns_o_r;
  assign out_step_count     = step_o_r;
  assign out_period_us      = period_o_r;
  assign out_velocity       = vel_o_r;
  assign out_angle          = angle_o_r;
  assign out_state_changed  = changed_o_r;

endmodule

>>> design/hall_sensor_position_velocity.sv
// Top level of the Hall sensor position and velocity decoder
// An accepted word steps through UPDATE, PREP, LOAD, CALC and DONE to out_valid;
// a new word is taken only back in IDLE. A held result does not block that accept.
// The radix-4 velocity divider bounds CALC; the angle multiply runs beside it.
// Synchronous active-low reset clears decoder state and loads config defaults.
module hall_sensor_position_velocity #(
  parameter int unsigned TIME_BITS = hsp_pkg::TIME_BITS_DEF,
  parameter int unsigned TURN_BITS = hsp_pkg::TURN_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic                              in_hall_a,
  input  logic                              in_hall_b,
  input  logic                              in_hall_c,
  input  logic [31:0]                       in_now_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [3:0]                 out_sector,
  output logic signed [1:0]                 out_turn_direction,
  output logic signed [31:0]                out_electric_turns,
  output logic signed [31:0]                out_step_count,
  output logic signed [31:0]                out_period_us,
  output logic signed [31:0]                out_velocity,
  output logic signed [hsp_pkg::ANGLE_W-1:0] out_angle,
  output logic                              out_state_changed
);
  import hsp_pkg::*;

  ctrl_cmd_t cmd;

  hsp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  hsp_datapath #(
    .TIME_BITS (TIME_BITS),
    .TURN_BITS (TURN_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_action),
    .in_hall_a          (in_hall_a),
    .in_hall_b          (in_hall_b),
    .in_hall_c          (in_hall_c),
    .in_now_us          (in_now_us),
    .out_sector         (out_sector),
    .out_turn_direction (out_turn_direction),
    .out_electric_turns (out_electric_turns),
    .out_step_count     (out_step_count),
    .out_period_us      (out_period_us),
    .out_velocity       (out_velocity),
    .out_angle          (out_angle),
    .out_state_changed  (out_state_changed)
  );

endmodule

>>> design/hsp_checker.sv
// Port-level assertion checker for the Hall decoder, bound to the top level
`include "hall_sensor_position_velocity_macros.svh"

module hsp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [3:0]                 out_sector,
  input logic signed [1:0]                 out_turn_direction,
  input logic signed [31:0]                out_period_us,
  input logic signed [31:0]                out_velocity
);

  `HSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped while stalled")

  `HSP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted a word while busy")

  `HSP_ASSERT_NOW(a_sector_range, out_valid, (out_sector >= -4'sd1) && (out_sector <= 4'sd5), "sector out of range")

  `HSP_ASSERT_NOW(a_vel_needs_dir, out_valid && (out_velocity != 32'sd0), out_turn_direction != 2'sd0, "velocity without direction")

  `HSP_ASSERT_NOW(a_period_needs_dir, out_valid && (out_turn_direction == 2'sd0), out_period_us == 32'sd0, "period before first edge")

endmodule

bind hall_sensor_position_velocity hsp_checker u_hsp_checker (.*);
